>>> hdl/bitmap_video_ram_writer_core_defines.svh
// Assertion macros for the top-level core, which checks itself.
// They expect clk and arst_n in scope.
`ifndef BITMAP_VIDEO_RAM_WRITER_CORE_DEFINES_SVH
`define BITMAP_VIDEO_RAM_WRITER_CORE_DEFINES_SVH

// same-cycle implication
`define BVW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BVW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/bvw_pkg.sv
package bvw_pkg;

	localparam int ADDR_BITS   = 16;
	localparam int STORE_DEPTH = 1 << ADDR_BITS;
	localparam int PIX_BITS    = 3;
	localparam int MAX_PIX     = 8;

	localparam logic [ADDR_BITS-1:0] BOTTOM_AREA = 16'hF800;
	// rows above this one show only color bits 2:1
	localparam logic [7:0] MASK_ROWS = 8'(231 - 32);

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [PIX_BITS-1:0]  pix_t;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_BYTE  = 2'd1,
		CMD_QUAD  = 2'd2,
		CMD_THIRD = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_SWAP_AXES = 3'd0,
		REG_MIRROR_X  = 3'd1,
		REG_MIRROR_Y  = 3'd2,
		REG_COCKTAIL  = 3'd3,
		REG_WIDTH_M1  = 3'd4,
		REG_HEIGHT_M1 = 3'd5
	} reg_idx_t;

	// one queued command, already broken down into pixels
	typedef struct packed {
		cmd_t         cmd;
		addr_t        base;
		logic [2:0]   cnt_m1;
		logic [7:0]   data;
		logic [7:0]   vis;
		logic [2:0]   last_idx;
	} op_t;

	typedef struct packed {
		logic       swap;
		logic       flip_x;
		logic       flip_y;
		logic [7:0] w_m1;
		logic [7:0] h_m1;
	} cfg_t;

	typedef struct packed {
		logic       is_pixel;
		logic [7:0] read_data;
		logic [7:0] x;
		logic [7:0] y;
		pix_t       color;
		logic       last;
	} result_t;

	typedef struct packed {
		logic clr_busy;
	} back_status_t;

	typedef struct packed {
		logic q_empty;
	} front_status_t;

endpackage

>>> hdl/bvw_ram.sv
module bvw_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a read of the address being written returns the old word
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

>>> hdl/bvw_front.sv
module bvw_front #(
	parameter int TOP_SKIP_ROWS = 25
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     cmd,
	input  logic [bvw_pkg::ADDR_BITS-1:0]  address,
	input  logic [7:0]                     data,
	input  logic                           busy,
	input  logic                           pop,
	output logic                           head_valid,
	output bvw_pkg::op_t                   head,
	output bvw_pkg::front_status_t         status
);

	import bvw_pkg::*;

	localparam logic [7:0] SKIP_ROW = 8'(TOP_SKIP_ROWS);

	cmd_t       cmd_c;
	op_t        op_c;
	addr_t      am1;
	addr_t      pa;
	logic       push;
	op_t        q_mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign am1 = address - addr_t'(1);

	always_comb begin
		cmd_c = cmd_t'(cmd);
		op_c = '0;
		op_c.cmd = cmd_c;
		op_c.data = data;
		case (cmd_c)
			CMD_QUAD: begin
				op_c.base = {address[ADDR_BITS-3:0], 2'b00};
				op_c.cnt_m1 = 3'd3;
			end
			CMD_THIRD: begin
				op_c.base = {am1[ADDR_BITS-3:0], 2'b00} + BOTTOM_AREA;
				op_c.cnt_m1 = 3'd7;
			end
			default: begin
				op_c.base = address;
				op_c.cnt_m1 = 3'd0;
			end
		endcase
		// a run of eight can straddle a row boundary, so look at each pixel
		pa = op_c.base;
		for (int i = 0; i < MAX_PIX; i++) begin
			pa = op_c.base + addr_t'(i);
			op_c.vis[i] = pa[ADDR_BITS-1 -: 8] >= SKIP_ROW;
			if (3'(i) <= op_c.cnt_m1 && op_c.vis[i])
				op_c.last_idx = 3'(i);
		end
	end

	assign in_ready = !busy && (cnt_q != 2'd2);
	assign push = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_mem[wr_ptr_q] <= op_c;
	end

	assign head_valid = cnt_q != 2'd0;
	assign head = q_mem[rd_ptr_q];
	assign status.q_empty = cnt_q == 2'd0;

endmodule

>>> hdl/bvw_back.sv
module bvw_back #(
	parameter int TOP_SKIP_ROWS = 25
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  bvw_pkg::op_t          head,
	output logic                  pop,
	input  bvw_pkg::cfg_t         cfg,
	output logic                  out_valid,
	input  logic                  out_ready,
	output bvw_pkg::result_t      out_res,
	output bvw_pkg::back_status_t status
);

	import bvw_pkg::*;

	localparam logic [7:0] SKIP_ROW = 8'(TOP_SKIP_ROWS);

	logic       clr_busy_q;
	addr_t      clr_addr_q;
	logic [2:0] idx_q;

	logic       valid_s1;
	addr_t      addr_s1;
	cmd_t       cmd_s1;
	logic [7:0] data_s1;
	logic       dbit_s1;
	logic       vis_s1;
	logic       last_s1;
	logic       fwd_s1;
	pix_t       fwd_val_s1;

	pix_t       rd_data;
	pix_t       old_val;
	pix_t       new_val;
	pix_t       color;
	addr_t      issue_addr;
	logic       issue;
	logic       s1_free;
	logic       emit;
	logic       fire;
	logic       wr_en;
	logic       out_space;
	logic       opush;
	logic       opop;
	logic       ram_we;
	addr_t      ram_waddr;
	pix_t       ram_wdata;
	logic [7:0] row_y;
	logic [7:0] xa;
	logic [7:0] ya;
	logic [7:0] xs;
	logic [7:0] ys;
	result_t    res_c;

	result_t    ofifo [2];
	logic       ow_q;
	logic       or_q;
	logic [1:0] ocnt_q;

	assign issue_addr = head.base + addr_t'(idx_q);
	// previous pixel wrote this address while we read it
	assign old_val = fwd_s1 ? fwd_val_s1 : rd_data;

	always_comb begin
		new_val = old_val;
		case (cmd_s1)
			CMD_READ:
				new_val = old_val;
			CMD_BYTE:
				new_val = {data_s1[7:6],
					data_s1[5] | ((addr_s1 >= BOTTOM_AREA) && old_val[0])};
			CMD_QUAD:
				new_val = {data_s1[7], data_s1[3], addr_s1 >= BOTTOM_AREA};
			CMD_THIRD:
				new_val = {old_val[2:1], dbit_s1};
			default:
				new_val = old_val;
		endcase
	end

	assign opop = out_valid && out_ready;
	assign out_space = (ocnt_q != 2'd2) || opop;
	assign emit = valid_s1 && ((cmd_s1 == CMD_READ) || vis_s1);
	assign fire = valid_s1 && (!emit || out_space);
	assign opush = fire && emit;
	assign wr_en = fire && (cmd_s1 != CMD_READ);
	assign s1_free = !valid_s1 || fire;
	assign issue = head_valid && !clr_busy_q && s1_free;
	assign pop = issue && (idx_q == head.cnt_m1);

	// screen coordinates; a mirror followed by the cocktail mirror cancels
	always_comb begin
		row_y = addr_s1[ADDR_BITS-1 -: 8] - SKIP_ROW;
		color = new_val;
		if (row_y < MASK_ROWS)
			color[0] = 1'b0;
		xa = cfg.swap ? row_y : addr_s1[7:0];
		ya = cfg.swap ? addr_s1[7:0] : row_y;
		xs = cfg.flip_x ? cfg.w_m1 - xa : xa;
		ys = cfg.flip_y ? cfg.h_m1 - ya : ya;
		res_c = '0;
		if (cmd_s1 == CMD_READ) begin
			res_c.read_data = {old_val, 5'b0};
			res_c.last = 1'b1;
		end else begin
			res_c.is_pixel = 1'b1;
			res_c.x = xs;
			res_c.y = ys;
			res_c.color = color;
			res_c.last = last_s1;
		end
	end

	assign ram_we = clr_busy_q || wr_en;
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_busy_q ? '0 : new_val;

	bvw_ram #(
		.WIDTH(PIX_BITS),
		.DEPTH(STORE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (issue_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			idx_q <= '0;
			valid_s1 <= 1'b0;
			ow_q <= 1'b0;
			or_q <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + addr_t'(1);
				if (clr_addr_q == '1)
					clr_busy_q <= 1'b0;
			end
			if (issue)
				idx_q <= pop ? 3'd0 : idx_q + 3'd1;
			if (issue)
				valid_s1 <= 1'b1;
			else if (fire)
				valid_s1 <= 1'b0;
			if (opush)
				ow_q <= !ow_q;
			if (opop)
				or_q <= !or_q;
			ocnt_q <= ocnt_q + 2'(opush) - 2'(opop);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			addr_s1 <= issue_addr;
			cmd_s1 <= head.cmd;
			data_s1 <= head.data;
			dbit_s1 <= head.data[idx_q];
			vis_s1 <= head.vis[idx_q];
			last_s1 <= idx_q == head.last_idx;
			fwd_s1 <= wr_en && (addr_s1 == issue_addr);
			fwd_val_s1 <= new_val;
		end
		if (opush)
			ofifo[ow_q] <= res_c;
	end

	assign out_valid = ocnt_q != 2'd0;
	assign out_res = ofifo[or_q];
	assign status.clr_busy = clr_busy_q;

endmodule

>>> hdl/bitmap_video_ram_writer_core.sv
// Bitmap video RAM writer: 64K pixels of 3 bits. A read or a byte write covers one pixel,
// a four-pixel write four and a third-bit write eight: every written pixel is one
// read-modify-write through the RAM's read and write ports, pipelined so that
// one pixel completes per cycle while results drain. Commands wait in a two-entry
// queue and results in a two-entry buffer, so either side may stall on its own.
// After reset the store is cleared with in_ready low; configuration writes are taken
// at any time (cfg_ready is always high) but are meant to be made while the block is idle.
`include "bitmap_video_ram_writer_core_defines.svh"

module bitmap_video_ram_writer_core #(
	parameter int TOP_SKIP_ROWS = 25
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    cmd,
	input  logic [bvw_pkg::ADDR_BITS-1:0] address,
	input  logic [7:0]                    data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          is_pixel,
	output logic [7:0]                    read_data,
	output logic [7:0]                    pixel_x,
	output logic [7:0]                    pixel_y,
	output logic [2:0]                    pixel_color,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_addr,
	input  logic [7:0]                    cfg_data
);

	import bvw_pkg::*;

	logic          swap_q;
	logic          mirror_x_q;
	logic          mirror_y_q;
	logic          cocktail_q;
	logic [7:0]    width_m1_q;
	logic [7:0]    height_m1_q;

	cfg_t          cfg;
	op_t           head;
	logic          head_valid;
	logic          pop;
	result_t       res;
	back_status_t  bst;
	front_status_t fst;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= 1'b0;
			mirror_x_q <= 1'b0;
			mirror_y_q <= 1'b0;
			cocktail_q <= 1'b1;
			width_m1_q <= 8'd255;
			height_m1_q <= 8'd230;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_addr))
				REG_SWAP_AXES: swap_q <= cfg_data[0];
				REG_MIRROR_X:  mirror_x_q <= cfg_data[0];
				REG_MIRROR_Y:  mirror_y_q <= cfg_data[0];
				REG_COCKTAIL:  cocktail_q <= cfg_data[0];
				REG_WIDTH_M1:  width_m1_q <= cfg_data;
				REG_HEIGHT_M1: height_m1_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.swap = swap_q;
		cfg.flip_x = mirror_x_q ^ cocktail_q;
		cfg.flip_y = mirror_y_q ^ cocktail_q;
		cfg.w_m1 = width_m1_q;
		cfg.h_m1 = height_m1_q;
	end

	bvw_front #(
		.TOP_SKIP_ROWS(TOP_SKIP_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.address    (address),
		.data       (data),
		.busy       (bst.clr_busy),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.status     (fst)
	);

	bvw_back #(
		.TOP_SKIP_ROWS(TOP_SKIP_ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.cfg        (cfg),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_res    (res),
		.status     (bst)
	);

	assign is_pixel = res.is_pixel;
	assign read_data = res.read_data;
	assign pixel_x = res.x;
	assign pixel_y = res.y;
	assign pixel_color = res.color;
	assign last = res.last;

	`BVW_ASSERT_IMP(a_no_result_in_clear, bst.clr_busy, !out_valid, "result during clear")
	`BVW_ASSERT_IMP(a_no_accept_in_clear, bst.clr_busy, !in_ready, "accept during clear")
	`BVW_ASSERT_IMP(a_queue_empty_after_clear, $fell(bst.clr_busy), fst.q_empty, "queue busy at clear end")
	`BVW_ASSERT_NXT(a_accept_queued, in_valid && in_ready, !fst.q_empty, "accepted item not queued")

endmodule

>>> tb/sv/tb.sv
module tb;
	import bvw_pkg::*;

	localparam int SKIP_ROWS    = 25;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 1_000_000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] cmd;
	addr_t      address;
	logic [7:0] data;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       is_pixel;
	logic [7:0] read_data;
	logic [7:0] pixel_x;
	logic [7:0] pixel_y;
	logic [2:0] pixel_color;
	logic       last;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_addr;
	logic [7:0] cfg_data;

	bitmap_video_ram_writer_core #(
		.TOP_SKIP_ROWS(SKIP_ROWS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.address    (address),
		.data       (data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.is_pixel   (is_pixel),
		.read_data  (read_data),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_color(pixel_color),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the pixel store and of the orientation registers
	pix_t       vram_shadow [0:STORE_DEPTH-1];
	logic       o_swap, o_mirror_x, o_mirror_y, o_cocktail;
	logic [7:0] o_width_m1, o_height_m1;

	result_t vram_results_q[$];
	result_t cmd_results[$];
	addr_t   touched_pix[$];

	logic idle_on = 1'b1;
	int   stall_left = 0;
	int   cycle_cnt = 0;
	int   fail_count = 0;
	int   n_items = 0;
	int   n_writes = 0;
	int   n_pix_results = 0;
	int   n_read_results = 0;
	int   n_settings = 0;

	function automatic void screen_update(addr_t a);
		logic [7:0] row;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] t;
		pix_t       col;
		result_t    r;
		row = a[15:8];
		if (row < SKIP_ROWS)
			return;
		y = row - 8'(SKIP_ROWS);
		x = a[7:0];
		col = vram_shadow[a];
		if (y < MASK_ROWS)
			col[0] = 1'b0;
		if (o_swap) begin
			t = x;
			x = y;
			y = t;
		end
		if (o_mirror_x)
			x = o_width_m1 - x;
		if (o_mirror_y)
			y = o_height_m1 - y;
		if (o_cocktail) begin
			x = o_width_m1 - x;
			y = o_height_m1 - y;
		end
		r = '0;
		r.is_pixel = 1'b1;
		r.x = x;
		r.y = y;
		r.color = col;
		cmd_results.push_back(r);
	endfunction

	function automatic void note_touched(addr_t a);
		touched_pix.push_back(a);
		if (touched_pix.size() > 64)
			void'(touched_pix.pop_front());
	endfunction

	function automatic void vram_execute(cmd_t c, addr_t a, logic [7:0] d);
		addr_t   base;
		addr_t   p;
		addr_t   tmp;
		pix_t    v;
		result_t r;
		int      i;
		cmd_results.delete();
		case (c)
			CMD_READ: begin
				r = '0;
				r.read_data = {vram_shadow[a], 5'b0};
				cmd_results.push_back(r);
			end
			CMD_BYTE: begin
				v = d[7:5];
				// bottom area keeps the old third bit set
				if (a >= BOTTOM_AREA && vram_shadow[a][0])
					v[0] = 1'b1;
				vram_shadow[a] = v;
				note_touched(a);
				screen_update(a);
			end
			CMD_QUAD: begin
				base = {a[13:0], 2'b00};
				v = {d[7], d[3], base >= BOTTOM_AREA};
				for (i = 0; i < 4; i++)
					vram_shadow[base + addr_t'(i)] = v;
				note_touched(base);
				for (i = 0; i < 4; i++)
					screen_update(base + addr_t'(i));
			end
			default: begin
				tmp = a - 16'd1;
				base = {tmp[13:0], 2'b00} + BOTTOM_AREA;
				for (i = 0; i < 8; i++) begin
					p = base + addr_t'(i);
					v = vram_shadow[p];
					v[0] = d[i];
					vram_shadow[p] = v;
					screen_update(p);
				end
				note_touched(base + addr_t'($urandom_range(0, 7)));
			end
		endcase
		for (i = 0; i < cmd_results.size(); i++) begin
			r = cmd_results[i];
			r.last = (i == cmd_results.size() - 1);
			vram_results_q.push_back(r);
		end
	endfunction

	task automatic send_item(input cmd_t c, input addr_t a, input logic [7:0] d);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 16);
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		cmd = c;
		address = a;
		data = d;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		vram_execute(c, a, d);
		n_items++;
		if (c != CMD_READ)
			n_writes++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_idle();
		while (vram_results_q.size() != 0)
			@(negedge clk);
		// writes into hidden rows give no result but may still be in flight
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
		cfg_valid = 1'b1;
		cfg_addr = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_SWAP_AXES: o_swap = val[0];
			REG_MIRROR_X:  o_mirror_x = val[0];
			REG_MIRROR_Y:  o_mirror_y = val[0];
			REG_COCKTAIL:  o_cocktail = val[0];
			REG_WIDTH_M1:  o_width_m1 = val;
			REG_HEIGHT_M1: o_height_m1 = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_orientation(input logic sw, input logic mx, input logic my,
			input logic ck, input logic [7:0] w_m1, input logic [7:0] h_m1);
		wait_idle();
		write_reg(REG_SWAP_AXES, {7'd0, sw});
		write_reg(REG_MIRROR_X, {7'd0, mx});
		write_reg(REG_MIRROR_Y, {7'd0, my});
		write_reg(REG_COCKTAIL, {7'd0, ck});
		write_reg(REG_WIDTH_M1, w_m1);
		write_reg(REG_HEIGHT_M1, h_m1);
		n_settings++;
	endtask

	// for part of each command kind, addresses that land on bottom-area pixels or that
	// reach recently written ones; the rest spans the whole address range
	task automatic send_random(input int count);
		cmd_t       c;
		addr_t      a;
		logic [7:0] d;
		int         sel;
		repeat (count) begin
			c = cmd_t'($urandom_range(0, 3));
			d = 8'($urandom_range(0, 255));
			sel = $urandom_range(0, 9);
			a = 16'($urandom);
			case (c)
				CMD_READ:
					if (sel < 7 && touched_pix.size() > 0)
						a = touched_pix[$urandom_range(0, touched_pix.size() - 1)];
				CMD_BYTE:
					if (sel < 3)
						a = BOTTOM_AREA | 16'($urandom_range(0, 16'h07FF));
					else if (sel < 5 && touched_pix.size() > 0)
						a = touched_pix[$urandom_range(0, touched_pix.size() - 1)];
				CMD_QUAD:
					if (sel < 3)
						a = 16'h3E00 + 16'($urandom_range(0, 16'h01FF));
				default:
					if (sel < 7)
						a = 16'($urandom_range(0, 16'h0201));
			endcase
			send_item(c, a, d);
		end
	endtask

	task automatic test_reset_reads();
		send_item(CMD_READ, 16'h0000, 8'hFF);
		send_item(CMD_READ, 16'hFFFF, 8'h00);
	endtask

	task automatic test_byte_write();
		send_item(CMD_BYTE, 16'h1900, 8'hFF);   // first visible row, bit 0 masked
		send_item(CMD_BYTE, 16'h18FF, 8'hE0);   // hidden row, stored only
		send_item(CMD_READ, 16'h18FF, 8'h00);
		send_item(CMD_BYTE, 16'hDFAA, 8'h3F);   // last masked row
		send_item(CMD_BYTE, 16'hE055, 8'hA0);   // first unmasked row
		send_item(CMD_BYTE, 16'hF800, 8'h20);
		send_item(CMD_BYTE, 16'hF800, 8'h00);   // old bit 0 sticks in bottom area
		send_item(CMD_READ, 16'hF800, 8'h00);
		send_item(CMD_BYTE, 16'hFFFF, 8'hE0);
		send_item(CMD_READ, 16'hFFFF, 8'h00);
	endtask

	task automatic test_quad_write();
		send_item(CMD_QUAD, 16'h3E00, 8'h88);   // bottom area adds the third bit
		send_item(CMD_QUAD, 16'h3DFF, 8'h80);
		send_item(CMD_QUAD, 16'hFFFF, 8'h08);   // block index wraps
		send_item(CMD_QUAD, 16'h4000, 8'hFF);   // wraps to hidden rows
		send_item(CMD_QUAD, 16'h0640, 8'h00);
	endtask

	task automatic test_third_bit();
		send_item(CMD_THIRD, 16'h0001, 8'hA5);
		send_item(CMD_THIRD, 16'h0000, 8'hFF);  // base just below bottom area
		send_item(CMD_THIRD, 16'h0200, 8'h5A);  // runs off the end into hidden rows
		send_item(CMD_THIRD, 16'h0201, 8'hFF);  // entirely hidden
		send_item(CMD_THIRD, 16'h0001, 8'h00);
		send_item(CMD_READ, 16'hF801, 8'h00);
		send_item(CMD_READ, 16'h0002, 8'h00);
	endtask

	task automatic test_orientation();
		set_orientation(1'b0, 1'b0, 1'b0, 1'b0, 8'd255, 8'd255);
		send_random(12);
		set_orientation(1'b1, 1'b1, 1'b1, 1'b0, 8'd0, 8'd0);
		send_random(12);
		set_orientation(1'b1, 1'b0, 1'b0, 1'b1, 8'd255, 8'd230);
		send_random(12);
		set_orientation(1'b0, 1'b1, 1'b1, 1'b1, 8'h80, 8'h7F);
		send_random(12);
		set_orientation(1'b1, 1'b1, 1'b0, 1'b0, 8'($urandom), 8'($urandom));
		send_random(12);
		set_orientation(1'b0, 1'b0, 1'b1, 1'b1, 8'($urandom), 8'($urandom));
		send_random(12);
	endtask

	task automatic test_random_traffic();
		int blk;
		for (blk = 0; blk < 6; blk++) begin
			set_orientation(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
				8'($urandom), 8'($urandom));
			idle_on = (blk < 5) && ($urandom_range(0, 3) != 0);
			send_random(47);
		end
	endtask

	// sink side stalls in bursts of random length
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_ready = 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 15);
			out_ready = 1'b0;
		end else begin
			out_ready = 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			got = {is_pixel, read_data, pixel_x, pixel_y, pixel_color, last};
			if (is_pixel)
				n_pix_results++;
			else
				n_read_results++;
			if (vram_results_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result pix=%0d rd=%h x=%0d y=%0d c=%0d last=%0d",
						got.is_pixel, got.read_data, got.x, got.y, got.color, got.last);
			end else begin
				want = vram_results_q.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: exp pix=%0d rd=%h x=%0d y=%0d c=%0d last=%0d%s",
							want.is_pixel, want.read_data, want.x, want.y, want.color,
							want.last, "");
					if (fail_count <= 10)
						$display("          got pix=%0d rd=%h x=%0d y=%0d c=%0d last=%0d",
							got.is_pixel, got.read_data, got.x, got.y, got.color, got.last);
				end
			end
		end
	end

	// store clear after reset fits well inside the cycle limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				vram_results_q.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_READ;
		address = '0;
		data = '0;
		cfg_valid = 1'b0;
		cfg_addr = REG_SWAP_AXES;
		cfg_data = '0;
		for (int i = 0; i < STORE_DEPTH; i++)
			vram_shadow[i] = '0;
		o_swap = 1'b0;
		o_mirror_x = 1'b0;
		o_mirror_y = 1'b0;
		o_cocktail = 1'b1;
		o_width_m1 = 8'd255;
		o_height_m1 = 8'd230;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_reset_reads();
		test_byte_write();
		test_quad_write();
		test_third_bit();
		test_orientation();
		test_random_traffic();
		idle_on = 1'b0;
		wait_idle();

		$display("%0d commands (%0d writes) over %0d orientation settings", n_items,
			n_writes, n_settings);
		$display("%0d pixel updates and %0d reads checked, %0d errors", n_pix_results,
			n_read_results, fail_count);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/bvw_pkg.sv
hdl/bvw_ram.sv
hdl/bvw_front.sv
hdl/bvw_back.sv
hdl/bitmap_video_ram_writer_core.sv
tb/sv/tb.sv
